@@ hw/rtl/assert_macros.svh @@
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define BNE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define BNE_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define BNE_ASSERT(lbl, clk, rst_n, prop, msg)
`define BNE_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

@@ hw/rtl/bne_pkg.sv @@
package bne_pkg;

    // gate opcodes
    typedef enum logic [2:0] {
        OP_LOAD  = 3'd0,
        OP_AND   = 3'd1,
        OP_XOR   = 3'd2,
        OP_INV   = 3'd3,
        OP_CONST = 3'd4,
        OP_COPY  = 3'd5,
        OP_PAIR  = 3'd6,
        OP_READ  = 3'd7
    } opcode_t;

    // result word kinds
    typedef enum logic {
        KIND_TRACE = 1'b0,
        KIND_READ  = 1'b1
    } kind_t;

    localparam int unsigned FIELD_W = 16;

endpackage

@@ hw/rtl/bne_gate_if.sv @@
interface bne_gate_if import bne_pkg::*;;
    logic               valid;
    logic               ready;
    logic [2:0]         opcode;
    logic [FIELD_W-1:0] src_wire_a;
    logic [FIELD_W-1:0] src_wire_b;
    logic [FIELD_W-1:0] dest_wire;
    logic               bit_value;

    modport source (
        output valid, opcode, src_wire_a, src_wire_b, dest_wire, bit_value,
        input  ready
    );

    modport sink (
        input  valid, opcode, src_wire_a, src_wire_b, dest_wire, bit_value,
        output ready
    );
endinterface

@@ hw/rtl/bne_result_if.sv @@
interface bne_result_if;
    logic valid;
    logic ready;
    logic result_kind;
    logic first_operand;
    logic second_operand;
    logic product;
    logic read_value;

    modport source (
        output valid, result_kind, first_operand, second_operand, product, read_value,
        input  ready
    );

    modport sink (
        input  valid, result_kind, first_operand, second_operand, product, read_value,
        output ready
    );
endinterface

@@ hw/rtl/boolean_netlist_evaluator_core.sv @@
// a gate word is registered in the evaluate stage, and its result word in the output word register
// throughput: one gate word per cycle while no result word is stalled, set by the single write port of the wire store
// the previous gate's write is forwarded, so back-to-back dependent gates run at full rate
// reset clears the pipeline and output valids; the wire store is not cleared
// and a wire reads as undefined until some gate or load has written it
`include "assert_macros.svh"

module boolean_netlist_evaluator_core import bne_pkg::*; #(
    parameter int unsigned WIRE_COUNT = 65536
) (
    input  logic         clk,
    input  logic         rst_n,
    bne_gate_if.sink     gate,
    bne_result_if.source result
);

    // address width of the wire store
    localparam int unsigned ADDR_W = $clog2(WIRE_COUNT);

    typedef logic [ADDR_W-1:0] addr_t;

    // wire store: one bit per wire, two read ports and one write port
    logic wire_mem [WIRE_COUNT];

    // index range checks on the incoming word
    logic  in_a_ok, in_b_ok, in_d_ok;
    addr_t in_a_addr, in_b_addr, in_d_addr;
    logic  accept;

    // evaluate stage, holds the gate while the store data comes back
    logic    s1_valid_reg, s1_valid_next;
    opcode_t s1_op_reg;
    logic    s1_a_ok_reg, s1_b_ok_reg, s1_d_ok_reg;
    addr_t   s1_a_addr_reg, s1_b_addr_reg, s1_d_addr_reg;
    logic    s1_bit_reg;

    // registered read data
    logic rd_a_reg, rd_b_reg;

    // last write, forwarded over the read-during-write of the same edge
    logic  fwd_valid_reg, fwd_valid_next;
    addr_t fwd_addr_reg;
    logic  fwd_bit_reg;

    // operand values and gate result
    logic va, vb;
    logic wr_bit;
    logic s1_emits, s1_writes, s1_adv;

    // output word register
    logic out_valid_reg, out_valid_next;
    logic out_kind_reg, out_first_reg, out_second_reg, out_prod_reg, out_read_reg;

    // ---------------------------------------------------------------
    // input side
    // ---------------------------------------------------------------
    assign in_a_ok   = 32'(gate.src_wire_a) < 32'(WIRE_COUNT);
    assign in_b_ok   = 32'(gate.src_wire_b) < 32'(WIRE_COUNT);
    assign in_d_ok   = 32'(gate.dest_wire)  < 32'(WIRE_COUNT);
    assign in_a_addr = ADDR_W'(gate.src_wire_a);
    assign in_b_addr = ADDR_W'(gate.src_wire_b);
    assign in_d_addr = ADDR_W'(gate.dest_wire);

    // a new word enters whenever the evaluate stage is empty or moving on
    assign gate.ready = !s1_valid_reg || s1_adv;
    assign accept     = gate.valid && gate.ready;

    // ---------------------------------------------------------------
    // wire store: reads issued on accept, write when the gate retires
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_a_reg <= wire_mem[in_a_addr];
            rd_b_reg <= wire_mem[in_b_addr];
        end
        if (s1_adv && s1_writes)
        begin
            wire_mem[s1_d_addr_reg] <= wr_bit;
        end
    end

    // ---------------------------------------------------------------
    // evaluate stage
    // ---------------------------------------------------------------
    // the store answers with the old value if the previous gate wrote the
    // same wire on the edge of the read; take the forwarded bit instead.
    // the forward register always matches the store, so a stale hit is harmless
    always_comb
    begin
        va = 1'b0;
        vb = 1'b0;
        if (s1_a_ok_reg)
        begin
            va = (fwd_valid_reg && fwd_addr_reg == s1_a_addr_reg) ? fwd_bit_reg : rd_a_reg;
        end
        if (s1_b_ok_reg)
        begin
            vb = (fwd_valid_reg && fwd_addr_reg == s1_b_addr_reg) ? fwd_bit_reg : rd_b_reg;
        end
    end

    always_comb
    begin
        unique case (s1_op_reg)
            OP_LOAD,
            OP_CONST: wr_bit = s1_bit_reg;
            OP_AND,
            OP_PAIR:  wr_bit = va & vb;
            OP_XOR:   wr_bit = va ^ vb;
            OP_INV:   wr_bit = ~va;
            OP_COPY:  wr_bit = va;
            OP_READ:  wr_bit = 1'b0;
            default:  wr_bit = 1'b0;
        endcase
    end

    // only a plain and and a read produce a result word
    assign s1_emits  = (s1_op_reg == OP_AND) || (s1_op_reg == OP_READ);
    // out-of-range destinations are dropped
    assign s1_writes = (s1_op_reg != OP_READ) && s1_d_ok_reg;
    // stall only when a word must go out and the output register is still full
    assign s1_adv    = s1_valid_reg && (!s1_emits || !out_valid_reg || result.ready);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        fwd_valid_next = fwd_valid_reg;
        if (s1_adv && s1_writes)
        begin
            fwd_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            fwd_valid_reg <= fwd_valid_next;
        end
    end

    // stage payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg     <= opcode_t'(gate.opcode);
            s1_a_ok_reg   <= in_a_ok;
            s1_b_ok_reg   <= in_b_ok;
            s1_d_ok_reg   <= in_d_ok;
            s1_a_addr_reg <= in_a_addr;
            s1_b_addr_reg <= in_b_addr;
            s1_d_addr_reg <= in_d_addr;
            s1_bit_reg    <= gate.bit_value;
        end
        if (s1_adv && s1_writes)
        begin
            fwd_addr_reg <= s1_d_addr_reg;
            fwd_bit_reg  <= wr_bit;
        end
    end

    // ---------------------------------------------------------------
    // output word register
    // ---------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_adv && s1_emits)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_emits)
        begin
            if (s1_op_reg == OP_READ)
            begin
                // read word: trace fields zero
                out_kind_reg   <= KIND_READ;
                out_first_reg  <= 1'b0;
                out_second_reg <= 1'b0;
                out_prod_reg   <= 1'b0;
                out_read_reg   <= va;
            end
            else
            begin
                // and-gate trace: read field zero
                out_kind_reg   <= KIND_TRACE;
                out_first_reg  <= va;
                out_second_reg <= vb;
                out_prod_reg   <= va & vb;
                out_read_reg   <= 1'b0;
            end
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.result_kind    = out_kind_reg;
    assign result.first_operand  = out_first_reg;
    assign result.second_operand = out_second_reg;
    assign result.product        = out_prod_reg;
    assign result.read_value     = out_read_reg;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    `BNE_ASSERT(a_stall_blocks_input, clk, rst_n,
        (s1_valid_reg && !s1_adv) |-> !gate.ready, "input taken while evaluate stage stalled")
    `BNE_ASSERT(a_emit_shows_word, clk, rst_n,
        (s1_adv && s1_emits) |=> result.valid, "retired and or read gave no result word")
    `BNE_ASSERT_NEVER(a_read_word_clean, clk, rst_n,
        result.valid && result.result_kind == KIND_READ
            && (result.first_operand || result.second_operand || result.product),
        "read word carries trace bits")
    `BNE_ASSERT(a_trace_product, clk, rst_n,
        (result.valid && result.result_kind == KIND_TRACE)
            |-> (result.product == (result.first_operand & result.second_operand))
            && !result.read_value,
        "trace product does not match operands")

endmodule

@@ test/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bne_pkg::*;

    // generous ceiling: every word with a long sender gap and every result with a long stall
    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int unsigned RANDOM_WORDS = 1200;
    localparam int unsigned CHUNK_WORDS  = 200;
    localparam int unsigned LONG_HOLD    = 400;

    typedef struct packed {
        opcode_t            opcode;
        logic [FIELD_W-1:0] src_a;
        logic [FIELD_W-1:0] src_b;
        logic [FIELD_W-1:0] dest;
        logic               bit_value;
    } gate_word_t;

    typedef struct packed {
        kind_t kind;
        logic  first;
        logic  second;
        logic  prod;
        logic  read_bit;
    } result_word_t;

    logic clk = 1'b0;
    logic rst_n;

    bne_gate_if   gate ();
    bne_result_if result ();

    boolean_netlist_evaluator_core #(
        .WIRE_COUNT(65536)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .gate   (gate),
        .result (result)
    );

    always #1ns clk = ~clk;

    // gate words waiting for the driver, filled by the stimulus block
    gate_word_t   gates_pending[$];
    // trace and read words the evaluator still owes us, oldest first
    result_word_t results_due[$];

    // our own copy of the wire store, updated as each gate word is accepted
    bit wire_bits [0:65535];

    // generator bookkeeping: wires holding a defined value, so no used source is unwritten
    bit                 gen_live [0:65535];
    logic [FIELD_W-1:0] live_list[$];
    logic [FIELD_W-1:0] last_dest;

    // idling controls, written only by the stimulus block at the falling edge
    bit          no_idle;
    int unsigned hold_requests;

    int unsigned gap_left;
    int unsigned stall_left;
    int unsigned hold_left;
    int unsigned holds_served;

    int unsigned words_taken = 0;
    int unsigned traces_seen = 0;
    int unsigned reads_seen  = 0;
    int unsigned failures    = 0;
    int unsigned cycles      = 0;

    // mostly short idle stretches, now and then a long one
    function automatic int unsigned idle_cycles();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // gate semantics: every operand is read before the destination is written
    function automatic void evaluate_gate(gate_word_t w);
        logic         va;
        logic         vb;
        result_word_t r;
        va = wire_bits[w.src_a];
        vb = wire_bits[w.src_b];
        r  = '{KIND_TRACE, 1'b0, 1'b0, 1'b0, 1'b0};
        case (w.opcode)
            OP_LOAD, OP_CONST:
                wire_bits[w.dest] = w.bit_value;
            OP_AND:
            begin
                wire_bits[w.dest] = va & vb;
                r.first  = va;
                r.second = vb;
                r.prod   = va & vb;
                results_due = {results_due, r};
            end
            OP_XOR:
                wire_bits[w.dest] = va ^ vb;
            OP_INV:
                wire_bits[w.dest] = ~va;
            OP_COPY:
                wire_bits[w.dest] = va;
            OP_PAIR:
                wire_bits[w.dest] = va & vb;
            OP_READ:
            begin
                r.kind     = KIND_READ;
                r.read_bit = va;
                results_due = {results_due, r};
            end
        endcase
    endfunction

    function automatic gate_word_t word(opcode_t op, logic [FIELD_W-1:0] a,
                                        logic [FIELD_W-1:0] b, logic [FIELD_W-1:0] d,
                                        logic v);
        gate_word_t w;
        w.opcode    = op;
        w.src_a     = a;
        w.src_b     = b;
        w.dest      = d;
        w.bit_value = v;
        return w;
    endfunction

    // favour the wire just written (forwarding), sometimes the extremes, else any live wire
    function automatic logic [FIELD_W-1:0] pick_source();
        int unsigned        r;
        logic [FIELD_W-1:0] c;
        r = $urandom_range(0, 9);
        if (r < 4 && gen_live[last_dest])
            return last_dest;
        if (r == 9)
        begin
            c = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            if (gen_live[c])
                return c;
        end
        return live_list[$urandom_range(0, live_list.size() - 1)];
    endfunction

    // well-formed netlist step: used sources are always live, unused fields carry noise
    function automatic gate_word_t random_gate();
        gate_word_t  w;
        int unsigned r;
        bit          uses_a;
        bit          uses_b;
        r = $urandom_range(0, 99);
        if (r < 14)
            w.opcode = OP_LOAD;
        else if (r < 34)
            w.opcode = OP_AND;
        else if (r < 44)
            w.opcode = OP_XOR;
        else if (r < 52)
            w.opcode = OP_INV;
        else if (r < 58)
            w.opcode = OP_CONST;
        else if (r < 64)
            w.opcode = OP_COPY;
        else if (r < 74)
            w.opcode = OP_PAIR;
        else
            w.opcode = OP_READ;
        w.src_a     = FIELD_W'($urandom_range(0, 16'hFFFF));
        w.src_b     = FIELD_W'($urandom_range(0, 16'hFFFF));
        w.bit_value = 1'($urandom_range(0, 1));
        uses_a = !(w.opcode inside {OP_LOAD, OP_CONST});
        uses_b = w.opcode inside {OP_AND, OP_XOR, OP_PAIR};
        if (uses_a)
            w.src_a = pick_source();
        if (uses_b)
            w.src_b = pick_source();
        r = $urandom_range(0, 19);
        if (r < 11)
            w.dest = FIELD_W'($urandom_range(0, 31));
        else if (r < 14)
            w.dest = FIELD_W'($urandom_range(0, 16'hFFFF));
        else if (r < 16)
            w.dest = last_dest;
        else if (r < 18 && uses_a)
            w.dest = w.src_a;
        else
            w.dest = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        return w;
    endfunction

    task automatic send(gate_word_t w);
        if (w.opcode != OP_READ)
        begin
            if (!gen_live[w.dest])
                live_list = {live_list, w.dest};
            gen_live[w.dest] = 1'b1;
            last_dest = w.dest;
        end
        gates_pending = {gates_pending, w};
    endtask

    // sender stops until the queue is empty, the last word is taken and every result is in
    task automatic drain();
        while (gates_pending.size() != 0 || gate.valid || results_due.size() != 0)
            @(negedge clk);
    endtask

    // driver: offer the next pending gate word, with random gaps between words
    always @(posedge clk or negedge rst_n)
    begin : gate_driver
        gate_word_t w;
        if (!rst_n)
        begin
            gate.valid      <= 1'b0;
            gate.opcode     <= OP_LOAD;
            gate.src_wire_a <= '0;
            gate.src_wire_b <= '0;
            gate.dest_wire  <= '0;
            gate.bit_value  <= 1'b0;
            gap_left        <= 0;
        end
        else
        begin
            if (gate.valid && gate.ready)
            begin
                evaluate_gate(word(opcode_t'(gate.opcode), gate.src_wire_a, gate.src_wire_b,
                                   gate.dest_wire, gate.bit_value));
                words_taken++;
            end
            if (!gate.valid || gate.ready)
            begin
                if (gap_left > 0)
                begin
                    gate.valid <= 1'b0;
                    gap_left   <= gap_left - 1;
                end
                else if (gates_pending.size() > 0)
                begin
                    w = gates_pending.pop_front();
                    gate.valid      <= 1'b1;
                    gate.opcode     <= w.opcode;
                    gate.src_wire_a <= w.src_a;
                    gate.src_wire_b <= w.src_b;
                    gate.dest_wire  <= w.dest;
                    gate.bit_value  <= w.bit_value;
                    gap_left <= (no_idle || $urandom_range(0, 99) < 60) ? 0 : idle_cycles();
                end
                else
                begin
                    gate.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each accepted result word and pace ready with stalls and long holds
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        result_word_t got;
        result_word_t want;
        if (!rst_n)
        begin
            result.ready <= 1'b0;
            stall_left   <= 0;
            hold_left    <= 0;
            holds_served <= 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                got = '{kind_t'(result.result_kind), result.first_operand,
                        result.second_operand, result.product, result.read_value};
                if (results_due.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("result word with nothing outstanding: ",
                                 "kind %b ops %b%b prod %b read %b",
                                 got.kind, got.first, got.second, got.prod, got.read_bit);
                end
                else
                begin
                    want = results_due.pop_front();
                    if (want.kind == KIND_READ)
                        reads_seen++;
                    else
                        traces_seen++;
                    if (got.kind !== want.kind || got.first !== want.first
                        || got.second !== want.second || got.prod !== want.prod
                        || got.read_bit !== want.read_bit)
                    begin
                        failures++;
                        if (failures <= 10)
                            $display("result mismatch: expected kind %b ops %b%b prod %b read %b,",
                                     want.kind, want.first, want.second, want.prod,
                                     want.read_bit,
                                     " got kind %b ops %b%b prod %b read %b",
                                     got.kind, got.first, got.second, got.prod, got.read_bit);
                    end
                end
            end

            // long hold-off asked for by the stimulus block, so the pipeline backs up
            if (holds_served != hold_requests)
            begin
                result.ready <= 1'b0;
                hold_left    <= LONG_HOLD;
                holds_served <= holds_served + 1;
            end
            else if (hold_left > 0)
            begin
                result.ready <= 1'b0;
                hold_left    <= hold_left - 1;
            end
            else if (stall_left > 0)
            begin
                result.ready <= 1'b0;
                stall_left   <= stall_left - 1;
            end
            else if (!no_idle && $urandom_range(0, 99) < 20)
            begin
                result.ready <= 1'b0;
                stall_left   <= idle_cycles() - 1;
            end
            else
            begin
                result.ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("run stopped by watchdog after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        int unsigned chunk;
        int unsigned n;
        no_idle       = 1'b0;
        hold_requests = 0;
        last_dest     = '0;
        rst_n <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: loads to both extreme wires and wire 1, with noise in the unused fields
        send(word(OP_LOAD,  16'hFFFF, 16'hFFFF, 16'h0000, 1'b1));
        send(word(OP_LOAD,  16'h0000, 16'h0000, 16'hFFFF, 1'b0));
        send(word(OP_LOAD,  16'h1234, 16'hEDCB, 16'h0001, 1'b1));
        // and traces: one-one, one-zero, zero-zero on the top wire
        send(word(OP_AND,   16'h0000, 16'h0001, 16'h0002, 1'b0));
        send(word(OP_AND,   16'h0000, 16'hFFFF, 16'h0003, 1'b1));
        send(word(OP_AND,   16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
        // silent gates
        send(word(OP_XOR,   16'h0000, 16'hFFFF, 16'h0004, 1'b1));
        send(word(OP_XOR,   16'h0002, 16'h0000, 16'h0004, 1'b0));
        send(word(OP_INV,   16'hFFFF, 16'hFFFF, 16'h0005, 1'b1));
        send(word(OP_CONST, 16'hFFFF, 16'hFFFF, 16'h0006, 1'b0));
        send(word(OP_CONST, 16'h0000, 16'h0000, 16'h0007, 1'b1));
        send(word(OP_COPY,  16'h0007, 16'hFFFF, 16'h0008, 1'b0));
        send(word(OP_PAIR,  16'h0007, 16'h0000, 16'h0009, 1'b0));
        send(word(OP_PAIR,  16'h0009, 16'h0006, 16'h000A, 1'b1));
        // reads, unused fields set both ways
        send(word(OP_READ,  16'h0009, 16'hFFFF, 16'hFFFF, 1'b1));
        send(word(OP_READ,  16'h000A, 16'h0000, 16'h0000, 1'b0));
        send(word(OP_READ,  16'h0004, 16'h5A5A, 16'hA5A5, 1'b1));
        send(word(OP_READ,  16'h0008, 16'h0000, 16'hFFFF, 1'b0));
        // gate writing its own source, then back-to-back dependants through forwarding
        send(word(OP_AND,   16'h0000, 16'h0003, 16'h0000, 1'b0));
        send(word(OP_INV,   16'h0000, 16'h0000, 16'h0000, 1'b0));
        send(word(OP_AND,   16'h0000, 16'h0000, 16'h0000, 1'b1));
        send(word(OP_READ,  16'h0000, 16'hFFFF, 16'h0000, 1'b0));
        send(word(OP_READ,  16'hFFFF, 16'h0000, 16'hFFFF, 1'b1));
        send(word(OP_COPY,  16'h0000, 16'h0000, 16'hFFFF, 1'b0));
        send(word(OP_READ,  16'hFFFF, 16'hFFFF, 16'h0000, 1'b0));
        drain();

        // random netlist in chunks, the sender pausing for all results after each one
        for (chunk = 0; chunk < RANDOM_WORDS / CHUNK_WORDS; chunk++)
        begin
            // one chunk with no idling at all, one starting under a long receiver hold
            no_idle = (chunk == 3);
            if (chunk == 2)
                hold_requests++;
            for (n = 0; n < CHUNK_WORDS; n++)
                send(random_gate());
            drain();
        end

        // wait past the pipeline depth for any stray result
        repeat (10) @(negedge clk);

        $display("sent %0d gate words across %0d distinct wires, directed then random netlist",
                 words_taken, live_list.size());
        $display("checked %0d and-gate traces and %0d wire reads, %0d failures",
                 traces_seen, reads_seen, failures);
        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
